// ===== src/i4dq_pkg.sv =====
// Package with the shared types and constants of the 4-bit dequantizing dot-product core.
`timescale 1ns / 1ps
`default_nettype none

package i4dq_pkg;

    localparam int ACT_BITS   = 16;
    localparam int NIB_BITS   = 4;
    localparam int DIFF_BITS  = NIB_BITS + 1;
    localparam int W_BITS     = 21;
    localparam int PROD_BITS  = ACT_BITS + W_BITS;
    localparam int PAIR_BITS  = PROD_BITS + 1;
    localparam int OUT_BITS   = 48;
    localparam int CFG_BITS   = 4;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NIB_ZERO   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_OFFSET = 1'd1;
    localparam logic [NIB_BITS-1:0]     NIB_ZERO_RESET = 4'd8;

    typedef struct packed {
        logic signed [ACT_BITS-1:0] act_first;
        logic signed [ACT_BITS-1:0] act_second;
        logic [7:0]                 weight_byte;
        logic signed [15:0]         group_scale;
        logic signed [15:0]         group_offset;
        logic                       last;
    } req_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] dot_product;
        logic                       saturated;
    } rsp_item_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEQ  = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic deq;
        logic mul;
        logic acc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_last;
    } status_t;

endpackage

`default_nettype wire

// ===== src/i4dq_ctrl.sv =====
// Sequencer that steps one request through dequantize, multiply, accumulate and emit.
`timescale 1ns / 1ps
`default_nettype none

module i4dq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire i4dq_pkg::status_t status,
    output i4dq_pkg::cmd_t        cmd
);
    import i4dq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEQ;
                end
            end
            S_DEQ:
            begin
                cmd.deq    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.item_last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/i4dq_datapath.sv =====
// Datapath with configuration, dequantizer, multipliers, saturating accumulator and output register.
`timescale 1ns / 1ps
`default_nettype none

module i4dq_datapath #(
    parameter int ACC_BITS = 48
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [i4dq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [i4dq_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire i4dq_pkg::req_item_t                   req_data,
    input  wire i4dq_pkg::cmd_t                        cmd,
    output i4dq_pkg::status_t                          status,
    output i4dq_pkg::rsp_item_t                        rsp_data
);
    import i4dq_pkg::*;

    logic [NIB_BITS-1:0] nib_zero_reg;
    logic                use_offset_reg;

    logic signed [ACT_BITS-1:0]  act0_reg;
    logic signed [ACT_BITS-1:0]  act1_reg;
    logic signed [DIFF_BITS-1:0] diff0_reg;
    logic signed [DIFF_BITS-1:0] diff1_reg;
    logic signed [DIFF_BITS-1:0] diff0_next;
    logic signed [DIFF_BITS-1:0] diff1_next;
    logic signed [15:0]          scale_reg;
    logic signed [15:0]          offset_reg;
    logic                        last_reg;

    logic signed [W_BITS-1:0]    w0_reg;
    logic signed [W_BITS-1:0]    w1_reg;
    logic signed [W_BITS-1:0]    w0_next;
    logic signed [W_BITS-1:0]    w1_next;
    logic signed [W_BITS-1:0]    scale_ext;
    logic signed [W_BITS-1:0]    offset_ext;

    logic signed [PROD_BITS-1:0] p0_reg;
    logic signed [PROD_BITS-1:0] p1_reg;
    logic signed [PROD_BITS-1:0] p0_next;
    logic signed [PROD_BITS-1:0] p1_next;

    logic signed [PAIR_BITS-1:0] pair;
    logic signed [ACC_BITS:0]    acc_sum;
    logic                        acc_ovf;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic                        clip_reg;
    logic                        clip_next;

    logic [OUT_BITS-1:0]         out_value;
    logic                        out_ovf;
    rsp_item_t                   rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_zero_reg   <= NIB_ZERO_RESET;
            use_offset_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NIB_ZERO)
            begin
                nib_zero_reg <= cfg_data[NIB_BITS-1:0];
            end
            if (cfg_index == CFG_USE_OFFSET)
            begin
                use_offset_reg <= cfg_data[0];
            end
        end
    end

    assign diff0_next = $signed({1'b0, req_data.weight_byte[NIB_BITS-1:0]})
                      - $signed({1'b0, nib_zero_reg});
    assign diff1_next = $signed({1'b0, req_data.weight_byte[2*NIB_BITS-1:NIB_BITS]})
                      - $signed({1'b0, nib_zero_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act0_reg   <= req_data.act_first;
            act1_reg   <= req_data.act_second;
            diff0_reg  <= diff0_next;
            diff1_reg  <= diff1_next;
            scale_reg  <= req_data.group_scale;
            offset_reg <= req_data.group_offset;
            last_reg   <= req_data.last;
        end
    end

    assign status.item_last = last_reg;

    // The dequantized weight is exact in 21 bits, so no rounding or clipping happens here.
    assign scale_ext  = {{(W_BITS-16){scale_reg[15]}}, scale_reg};
    assign offset_ext = use_offset_reg ? {{(W_BITS-16){offset_reg[15]}}, offset_reg} : '0;
    assign w0_next = $signed({{(W_BITS-DIFF_BITS){diff0_reg[DIFF_BITS-1]}}, diff0_reg})
                   * scale_ext + offset_ext;
    assign w1_next = $signed({{(W_BITS-DIFF_BITS){diff1_reg[DIFF_BITS-1]}}, diff1_reg})
                   * scale_ext + offset_ext;

    assign p0_next = $signed({{(PROD_BITS-ACT_BITS){act0_reg[ACT_BITS-1]}}, act0_reg})
                   * $signed({{(PROD_BITS-W_BITS){w0_reg[W_BITS-1]}}, w0_reg});
    assign p1_next = $signed({{(PROD_BITS-ACT_BITS){act1_reg[ACT_BITS-1]}}, act1_reg})
                   * $signed({{(PROD_BITS-W_BITS){w1_reg[W_BITS-1]}}, w1_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.deq)
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
        end
        if (cmd.mul)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
    end

    assign pair = {p0_reg[PROD_BITS-1], p0_reg} + {p1_reg[PROD_BITS-1], p1_reg};
    assign acc_sum = {acc_reg[ACC_BITS-1], acc_reg}
                   + {{(ACC_BITS+1-PAIR_BITS){pair[PAIR_BITS-1]}}, pair};
    assign acc_ovf = acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1];

    generate
        if (ACC_BITS > OUT_BITS)
        begin : g_clamp
            logic [ACC_BITS-OUT_BITS:0] top;
            assign top       = acc_reg[ACC_BITS-1:OUT_BITS-1];
            assign out_ovf   = !((&top) || !(|top));
            assign out_value = !out_ovf ? acc_reg[OUT_BITS-1:0]
                             : (acc_reg[ACC_BITS-1] ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                                    : {1'b0, {(OUT_BITS-1){1'b1}}});
        end
        else if (ACC_BITS == OUT_BITS)
        begin : g_same
            assign out_ovf   = 1'b0;
            assign out_value = acc_reg;
        end
        else
        begin : g_extend
            assign out_ovf   = 1'b0;
            assign out_value = {{(OUT_BITS-ACC_BITS){acc_reg[ACC_BITS-1]}}, acc_reg};
        end
    endgenerate

    always_comb
    begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        if (cmd.acc)
        begin
            if (acc_ovf)
            begin
                acc_next  = acc_sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                              : {1'b0, {(ACC_BITS-1){1'b1}}};
                clip_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum[ACC_BITS-1:0];
            end
        end
        else if (cmd.emit)
        begin
            acc_next  = '0;
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.dot_product <= out_value;
            rsp_reg.saturated   <= clip_reg || out_ovf;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

// ===== src/int4_dequant_dot_product_core.sv =====
// Top level of the dot-product core for 4-bit packed weights with group dequantization.
// The feeder sends requests on req_valid/req_ready/req_data: one weight byte, two Q8.8
// activations, the group's Q4.12 scale and offset, and a last flag. The low nibble pairs
// with act_first and the high nibble with act_second. Each request runs through four
// controller steps: accept, dequantize (nibble minus zero point, times scale, plus offset
// when use_offset is set), multiply by the activations, and one saturating add into the
// accumulator. A new request is taken only once the previous one is through all of its
// steps. On a request marked last, one extra step clamps the sum to 48 bits and loads the
// output register once it is empty or being drained, and the result then appears on
// rsp_valid/rsp_data. The accumulator and the clip flag are cleared when the result is
// loaded. If the receiver holds rsp_ready low, the result stays in the output register;
// a following dot product keeps running and waits only at its own output step.
// Configuration writes (zero point, use_offset) take effect at once; the user must make
// them while the core is idle, which the core does not enforce. Reset sets the zero point
// to 8, use_offset to 0, and clears the accumulator, the clip flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module int4_dequant_dot_product_core #(
    parameter int ACC_BITS = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [i4dq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [i4dq_pkg::CFG_BITS-1:0]     cfg_data,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire i4dq_pkg::req_item_t               req_data,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output i4dq_pkg::rsp_item_t                    rsp_data
);
    import i4dq_pkg::*;

    cmd_t    cmd;
    status_t status;

    i4dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    i4dq_datapath #(
        .ACC_BITS (ACC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_data  (rsp_data)
    );

    // At most one datapath step is commanded in any cycle.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath step commanded");

    // A request is never taken while the previous one is still being processed.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    // The output register is only loaded when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid || rsp_ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the 4-bit dequantizing dot-product core.
`timescale 1ns / 1ps

module tb;

    import i4dq_pkg::*;

    localparam int ACC_W        = 48;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_data = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_data;

    logic [3:0] zp_reg = NIB_ZERO_RESET;
    bit         offset_on = 1'b0;
    longint     dot_acc = 0;
    bit         clip_flag = 1'b0;
    rsp_item_t  pending_dots[$];
    rsp_item_t  dot_front;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    int4_dequant_dot_product_core #(
        .ACC_BITS(ACC_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint dequant_weight(input logic [3:0] nib,
                                              input logic signed [15:0] scale,
                                              input logic signed [15:0] offset);
        longint w;
        w = (longint'(nib) - longint'(zp_reg)) * longint'(scale);
        if (offset_on)
            w += longint'(offset);
        return w;
    endfunction

    function automatic void accumulate_request(input req_item_t r);
        longint pair;
        longint hi;
        longint lo;
        longint ohi;
        longint olo;
        longint dot;
        rsp_item_t res;
        hi = (longint'(1) <<< (ACC_W - 1)) - 1;
        lo = -hi - 1;
        ohi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
        olo = -ohi - 1;
        pair = longint'($signed(r.act_first))
                   * dequant_weight(r.weight_byte[3:0], r.group_scale, r.group_offset)
             + longint'($signed(r.act_second))
                   * dequant_weight(r.weight_byte[7:4], r.group_scale, r.group_offset);
        if (pair > 0 && dot_acc > hi - pair)
        begin
            dot_acc = hi;
            clip_flag = 1'b1;
        end
        else if (pair < 0 && dot_acc < lo - pair)
        begin
            dot_acc = lo;
            clip_flag = 1'b1;
        end
        else
        begin
            dot_acc += pair;
        end
        if (r.last)
        begin
            dot = dot_acc;
            if (dot > ohi)
            begin
                dot = ohi;
                clip_flag = 1'b1;
            end
            else if (dot < olo)
            begin
                dot = olo;
                clip_flag = 1'b1;
            end
            res.dot_product = dot[OUT_BITS-1:0];
            res.saturated = clip_flag;
            pending_dots.push_back(res);
            dot_acc = 0;
            clip_flag = 1'b0;
        end
    endfunction

    function automatic req_item_t make_req(input logic [15:0] a0, input logic [15:0] a1,
                                           input logic [7:0] wb, input logic [15:0] sc,
                                           input logic [15:0] ofs, input logic last);
        req_item_t r;
        r.act_first = a0;
        r.act_second = a1;
        r.weight_byte = wb;
        r.group_scale = sc;
        r.group_offset = ofs;
        r.last = last;
        return r;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic req_item_t random_req(input logic last);
        return make_req(pick16(), pick16(), 8'($urandom_range(255)), pick16(), pick16(),
                        last);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_dots.size() == 0)
            begin
                $display("%0t: result with none pending: dot_product=%0d saturated=%0b",
                         $time, rsp_data.dot_product, rsp_data.saturated);
                fail_count++;
            end
            else
            begin
                dot_front = pending_dots.pop_front();
                if (rsp_data.dot_product !== dot_front.dot_product)
                begin
                    $display("%0t: dot_product mismatch: expected %0d, actual %0d",
                             $time, dot_front.dot_product, rsp_data.dot_product);
                    fail_count++;
                end
                if (rsp_data.saturated !== dot_front.saturated)
                begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $time, dot_front.saturated, rsp_data.saturated);
                    fail_count++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input req_item_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data <= item;
        do
            @(posedge clk);
        while (!req_ready);
        accumulate_request(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_NIB_ZERO)
            zp_reg = value;
        else if (idx == CFG_USE_OFFSET)
            offset_on = value[0];
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_item(make_req(16'h7FFF, 16'h7FFF, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_item(make_req(16'h8000, 16'h8000, 8'h00, 16'h8000, 16'h8000, 1'b1));
        send_item(make_req(16'h7FFF, 16'h8000, 8'h88, 16'h7FFF, 16'h1234, 1'b0));
        send_item(make_req(16'h0001, 16'hFFFF, 8'h0F, 16'h0001, 16'h0000, 1'b0));
        send_item(make_req(16'hFFFF, 16'h0100, 8'hF0, 16'h1000, 16'h7FFF, 1'b1));
        send_item(make_req(16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1));
        wait_for_results();
        write_reg(CFG_NIB_ZERO, 4'd15);
        write_reg(CFG_USE_OFFSET, 4'd1);
        send_item(make_req(16'h7FFF, 16'h8000, 8'hFF, 16'h7FFF, 16'h8000, 1'b0));
        send_item(make_req(16'h8000, 16'h8000, 8'h00, 16'h8000, 16'h7FFF, 1'b1));
        send_item(make_req(16'h5555, 16'hAAAA, 8'hA5, 16'h5555, 16'hAAAA, 1'b0));
        send_item(make_req(16'hAAAA, 16'h5555, 8'h5A, 16'hAAAA, 16'h5555, 1'b1));
        send_item(make_req(16'h0100, 16'hFF00, 8'h3C, 16'h0000, 16'h8000, 1'b1));
        wait_for_results();
        write_reg(CFG_NIB_ZERO, 4'd0);
        send_item(make_req(16'h8000, 16'h8000, 8'hFF, 16'h8000, 16'h8000, 1'b1));
        send_item(make_req(16'h7FFF, 16'h8000, 8'h00, 16'h7FFF, 16'h7FFF, 1'b1));
        send_item(make_req(16'h7FFF, 16'h7FFF, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_item(make_req(16'h8000, 16'h7FFF, 8'hF0, 16'h8000, 16'h0001, 1'b1));
        wait_for_results();
        write_reg(CFG_NIB_ZERO, NIB_ZERO_RESET);
        write_reg(CFG_USE_OFFSET, 4'd0);
    endtask

    task automatic test_large_sums();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_NIB_ZERO, 4'd0);
        write_reg(CFG_USE_OFFSET, 4'd1);
        for (k = 0; k < 40; k++)
            send_item(make_req(16'h8000, 16'h8000, 8'hFF, 16'h8000, 16'h8000, 1'b0));
        for (k = 0; k < 3; k++)
            send_item(make_req(16'h7FFF, 16'h7FFF, 8'hFF, 16'h8000, 16'h8000, k == 2));
        for (k = 0; k < 40; k++)
            send_item(make_req(16'h7FFF, 16'h7FFF, 8'hFF, 16'h8000, 16'h8000, k == 39));
        send_item(make_req(16'h0100, 16'h0100, 8'h12, 16'h1000, 16'h0000, 1'b1));
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int sent;
        int len;
        int k;
        bit paused;
        sent = 0;
        paused = 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(CFG_NIB_ZERO, 4'($urandom_range(15)));
        write_reg(CFG_USE_OFFSET, 4'($urandom_range(1)));
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            for (k = 0; k < len; k++)
                send_item(random_req(k == len - 1));
            sent += len;
            // The sender holds off mid-phase until every result is back.
            if (!paused && sent >= n_items / 2)
            begin
                paused = 1'b1;
                wait_for_results();
                write_reg(CFG_NIB_ZERO, 4'($urandom_range(15)));
                write_reg(CFG_USE_OFFSET, 4'($urandom_range(1)));
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_large_sums();
        test_random_traffic(34, 84, 195);
        test_random_traffic(84, 34, 195);
        test_random_traffic(0, 0, 195);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
